// ----- rtl/core/gated_qc_beam_statistics_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the beam statistics core.
// ----------------------------------------------------------------------------
`ifndef GATED_QC_BEAM_STATISTICS_CORE_MACROS_SVH
`define GATED_QC_BEAM_STATISTICS_CORE_MACROS_SVH

// same-cycle implication
`define GQBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gqbs: same-cycle check failed");

// next-cycle implication
`define GQBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gqbs: next-cycle check failed");

`endif

// ----- rtl/core/gqbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Beam statistics package
// Widths, register indexes and the control/status types of the core.
// ----------------------------------------------------------------------------
package gqbs_pkg;

   localparam int MaxGates  = 4096;
   localparam int GateW     = $clog2(MaxGates + 1);
   localparam int CountW    = $clog2(MaxGates + 1);
   localparam int CfgGateW  = 12;
   localparam int SampleW   = 16;
   localparam int SumW      = 29;
   localparam int FracW     = 8;
   localparam int MeanW     = 24;
   localparam int QuotW     = 24;
   localparam int DivShift  = QuotW - FracW;
   localparam int StepW     = $clog2(QuotW);
   localparam int TotalW    = 32;
   localparam int AddrW     = 4;
   localparam int DataW     = 32;

   typedef enum logic [1:0] {
      REG_FIRST_GATE = 2'd0,
      REG_FINAL_GATE = 2'd1,
      REG_QC_LOW     = 2'd2,
      REG_QC_HIGH    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CfgGateW-1:0] first_gate;
      logic [CfgGateW-1:0] final_gate;
      logic [SampleW-1:0]  qc_low;
      logic [SampleW-1:0]  qc_high;
   } cfg_type;

   typedef struct packed {
      logic accumulate;
      logic div_load;
      logic div_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_last;
   } dp_status_type;

endpackage

// ----- rtl/core/gqbs_csr.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style window and threshold registers; thresholds read back with sign extension.
// ----------------------------------------------------------------------------
module gqbs_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gqbs_pkg::AddrW-1:0]  paddr,
   input  logic [gqbs_pkg::DataW-1:0]  pwdata,
   output logic [gqbs_pkg::DataW-1:0]  prdata,
   output logic                        pready,
   output gqbs_pkg::cfg_type           cfg
);
   import gqbs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[AddrW-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_FIRST_GATE: cfg_in.first_gate = pwdata[CfgGateW-1:0];
            REG_FINAL_GATE: cfg_in.final_gate = pwdata[CfgGateW-1:0];
            REG_QC_LOW:     cfg_in.qc_low     = pwdata[SampleW-1:0];
            REG_QC_HIGH:    cfg_in.qc_high    = pwdata[SampleW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FIRST_GATE: prdata = DataW'(cfg_ff.first_gate);
         REG_FINAL_GATE: prdata = DataW'(cfg_ff.final_gate);
         REG_QC_LOW:     prdata = {{(DataW-SampleW){cfg_ff.qc_low[SampleW-1]}}, cfg_ff.qc_low};
         REG_QC_HIGH:    prdata = {{(DataW-SampleW){cfg_ff.qc_high[SampleW-1]}},
                                   cfg_ff.qc_high};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_gate <= '0;
         cfg_ff.final_gate <= '1;
         cfg_ff.qc_low     <= {1'b1, {(SampleW-1){1'b0}}};
         cfg_ff.qc_high    <= {1'b0, {(SampleW-1){1'b1}}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/gqbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Beam statistics controller
// Sequences accumulation, mean division and result hand-off.
// ----------------------------------------------------------------------------
module gqbs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_beam_end,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  gqbs_pkg::dp_status_type   status,
   output gqbs_pkg::ctrl_cmd_type    cmd
);
   import gqbs_pkg::*;

   typedef enum logic [3:0] {
      ST_ACCUM  = 4'b0001,
      ST_PREP   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_full_ff;
   logic      out_full_in;
   logic      out_free;
   logic      accept;

   assign req_ready = (state_ff == ST_ACCUM);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = out_full_ff;
   assign out_free  = ~out_full_ff | rsp_ready;

   assign cmd.accumulate = accept;
   assign cmd.div_load   = (state_ff == ST_PREP);
   assign cmd.div_step   = (state_ff == ST_DIVIDE);
   assign cmd.finish     = (state_ff == ST_FINISH) & out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (accept && req_beam_end) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.count_zero ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_ACCUM;
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      out_full_in = out_full_ff;
      if (cmd.finish) begin
         out_full_in = 1'b1;
      end else if (rsp_ready) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_ACCUM;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

endmodule

// ----- rtl/core/gqbs_datapath.sv -----
// ----------------------------------------------------------------------------
// Beam statistics datapath
// Gate window and threshold qualification, per-beam accumulators,
// restoring mean divider and file-wide extremes with result register.
// ----------------------------------------------------------------------------
module gqbs_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gqbs_pkg::cfg_type                    cfg,
   input  gqbs_pkg::ctrl_cmd_type               cmd,
   output gqbs_pkg::dp_status_type              status,
   input  logic signed [gqbs_pkg::SampleW-1:0]  req_sample,
   output logic        [gqbs_pkg::CountW-1:0]   rsp_beam_count,
   output logic signed [gqbs_pkg::SampleW-1:0]  rsp_beam_min,
   output logic signed [gqbs_pkg::SampleW-1:0]  rsp_beam_max,
   output logic signed [gqbs_pkg::MeanW-1:0]    rsp_beam_mean,
   output logic signed [gqbs_pkg::MeanW-1:0]    rsp_overall_min_mean,
   output logic signed [gqbs_pkg::MeanW-1:0]    rsp_overall_max_mean,
   output logic        [gqbs_pkg::TotalW-1:0]   rsp_overall_count,
   output logic                                 rsp_overall_valid
);
   import gqbs_pkg::*;

   logic        [GateW-1:0]   gate_index_ff, gate_index_in;
   logic signed [SumW-1:0]    run_sum_ff, run_sum_in;
   logic        [CountW-1:0]  run_count_ff, run_count_in;
   logic signed [SampleW-1:0] run_min_ff, run_min_in;
   logic signed [SampleW-1:0] run_max_ff, run_max_in;
   logic        [TotalW-1:0]  total_count_ff, total_count_in;
   logic signed [MeanW-1:0]   lowest_mean_ff, lowest_mean_in;
   logic signed [MeanW-1:0]   highest_mean_ff, highest_mean_in;
   logic                      seen_valid_ff, seen_valid_in;

   logic                      neg_ff, neg_in;
   logic        [CountW-1:0]  rem_ff, rem_in;
   logic        [QuotW-1:0]   quo_ff, quo_in;
   logic        [StepW-1:0]   step_ff, step_in;

   logic                      in_gate;
   logic                      in_range;
   logic                      take;
   logic        [SumW-1:0]    mag;
   logic        [CountW-1:0]  trial;
   logic                      fits;
   logic signed [MeanW-1:0]   mean;
   logic        [TotalW:0]    total_sum;

   assign in_gate  = (gate_index_ff < GateW'(MaxGates))
                   && (gate_index_ff >= GateW'(cfg.first_gate))
                   && (gate_index_ff <= GateW'(cfg.final_gate));
   assign in_range = (req_sample > $signed(cfg.qc_low)) && (req_sample < $signed(cfg.qc_high));
   assign take     = cmd.accumulate & in_gate & in_range;

   assign mag   = run_sum_ff[SumW-1] ? SumW'(-run_sum_ff) : SumW'(run_sum_ff);
   assign trial = {rem_ff[CountW-2:0], quo_ff[QuotW-1]};
   assign fits  = (trial >= run_count_ff);

   assign mean      = (run_count_ff == '0) ? '0
                    : (neg_ff ? $signed(-quo_ff) : $signed(quo_ff));
   assign total_sum = {1'b0, total_count_ff} + (TotalW+1)'(run_count_ff);

   assign status.count_zero = (run_count_ff == '0);
   assign status.div_last   = (step_ff == StepW'(QuotW - 1));

   always_comb begin
      gate_index_in = gate_index_ff;
      run_sum_in    = run_sum_ff;
      run_count_in  = run_count_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      if (cmd.accumulate && (gate_index_ff < GateW'(MaxGates))) begin
         gate_index_in = gate_index_ff + GateW'(1);
      end
      if (take) begin
         run_sum_in   = run_sum_ff + SumW'(req_sample);
         run_count_in = run_count_ff + CountW'(1);
         if (run_count_ff == '0) begin
            run_min_in = req_sample;
            run_max_in = req_sample;
         end else begin
            if (req_sample < run_min_ff) run_min_in = req_sample;
            if (req_sample > run_max_ff) run_max_in = req_sample;
         end
      end
      if (cmd.finish) begin
         gate_index_in = '0;
         run_sum_in    = '0;
         run_count_in  = '0;
         run_min_in    = '0;
         run_max_in    = '0;
      end
   end

   always_comb begin
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (cmd.div_load) begin
         neg_in  = run_sum_ff[SumW-1];
         rem_in  = CountW'(mag >> DivShift);
         quo_in  = {mag[DivShift-1:0], {FracW{1'b0}}};
         step_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = fits ? (trial - run_count_ff) : trial;
         quo_in  = {quo_ff[QuotW-2:0], fits};
         step_in = step_ff + StepW'(1);
      end
   end

   always_comb begin
      total_count_in  = total_count_ff;
      lowest_mean_in  = lowest_mean_ff;
      highest_mean_in = highest_mean_ff;
      seen_valid_in   = seen_valid_ff;
      if (cmd.finish && (run_count_ff != '0)) begin
         seen_valid_in  = 1'b1;
         total_count_in = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
         if (!seen_valid_ff) begin
            lowest_mean_in  = mean;
            highest_mean_in = mean;
         end else begin
            if (mean < lowest_mean_ff)  lowest_mean_in  = mean;
            if (mean > highest_mean_ff) highest_mean_in = mean;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_index_ff   <= '0;
         run_sum_ff      <= '0;
         run_count_ff    <= '0;
         run_min_ff      <= '0;
         run_max_ff      <= '0;
         total_count_ff  <= '0;
         lowest_mean_ff  <= '0;
         highest_mean_ff <= '0;
         seen_valid_ff   <= 1'b0;
         step_ff         <= '0;
      end else begin
         gate_index_ff   <= gate_index_in;
         run_sum_ff      <= run_sum_in;
         run_count_ff    <= run_count_in;
         run_min_ff      <= run_min_in;
         run_max_ff      <= run_max_in;
         total_count_ff  <= total_count_in;
         lowest_mean_ff  <= lowest_mean_in;
         highest_mean_ff <= highest_mean_in;
         seen_valid_ff   <= seen_valid_in;
         step_ff         <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // result register, loaded with the updated file-wide figures
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_beam_count       <= run_count_ff;
         rsp_beam_min         <= run_min_ff;
         rsp_beam_max         <= run_max_ff;
         rsp_beam_mean        <= mean;
         rsp_overall_min_mean <= lowest_mean_in;
         rsp_overall_max_mean <= highest_mean_in;
         rsp_overall_count    <= total_count_in;
         rsp_overall_valid    <= seen_valid_in;
      end
   end

endmodule

// ----- rtl/core/gated_qc_beam_statistics_core.sv -----
// ----------------------------------------------------------------------------
// Gated QC beam statistics core
// Per-beam count, sum, extremes and mean of gated, thresholded samples,
// with file-wide mean extremes and a saturating total count.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             transaction
//   req_      in         req_valid/req_ready   one gate sample, beam_end flag
//   rsp_      out        rsp_valid/rsp_ready   one beam summary
//   csr       in         psel/penable/pready   register write or read
//
// Samples are taken one per cycle while req_ready is high. The sample flagged
// beam_end is followed by a set-up state, the restoring divider (one mean bit a
// cycle) and a finish state, without intake; a beam with no samples skips the divider.
// The finish cycle waits while the result register is still full.
// Synchronous reset; no clearing pass.
module gated_qc_beam_statistics_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [gqbs_pkg::SampleW-1:0]  req_sample,
   input  logic                                 req_beam_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [gqbs_pkg::CountW-1:0]   rsp_beam_count,
   output logic signed [gqbs_pkg::SampleW-1:0]  rsp_beam_min,
   output logic signed [gqbs_pkg::SampleW-1:0]  rsp_beam_max,
   output logic signed [gqbs_pkg::MeanW-1:0]    rsp_beam_mean,
   output logic signed [gqbs_pkg::MeanW-1:0]    rsp_overall_min_mean,
   output logic signed [gqbs_pkg::MeanW-1:0]    rsp_overall_max_mean,
   output logic        [gqbs_pkg::TotalW-1:0]   rsp_overall_count,
   output logic                                 rsp_overall_valid,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic        [gqbs_pkg::AddrW-1:0]    paddr,
   input  logic        [gqbs_pkg::DataW-1:0]    pwdata,
   output logic        [gqbs_pkg::DataW-1:0]    prdata,
   output logic                                 pready
);
   import gqbs_pkg::*;

   `include "gated_qc_beam_statistics_core_macros.svh"

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   gqbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gqbs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_beam_end (req_beam_end),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .cmd          (cmd)
   );

   gqbs_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .status               (status),
      .req_sample           (req_sample),
      .rsp_beam_count       (rsp_beam_count),
      .rsp_beam_min         (rsp_beam_min),
      .rsp_beam_max         (rsp_beam_max),
      .rsp_beam_mean        (rsp_beam_mean),
      .rsp_overall_min_mean (rsp_overall_min_mean),
      .rsp_overall_max_mean (rsp_overall_max_mean),
      .rsp_overall_count    (rsp_overall_count),
      .rsp_overall_valid    (rsp_overall_valid)
   );

   `GQBS_ASSERT_IMPL(a_empty_beam_zero, clock, reset,
      rsp_valid && (rsp_beam_count == '0),
      (rsp_beam_mean == '0) && (rsp_beam_min == '0) && (rsp_beam_max == '0))
   `GQBS_ASSERT_IMPL(a_extremes_order, clock, reset,
      rsp_valid && (rsp_beam_count != '0),
      rsp_overall_valid && (rsp_beam_min <= rsp_beam_max)
      && (rsp_overall_min_mean <= rsp_overall_max_mean))
   `GQBS_ASSERT_IMPL(a_total_covers_beam, clock, reset,
      rsp_valid, rsp_overall_count >= TotalW'(rsp_beam_count))
   `GQBS_ASSERT_NEXT(a_beam_end_stalls, clock, reset,
      req_valid && req_ready && req_beam_end, !req_ready)

endmodule

// ----- tb/tb_gated_qc_beam_statistics_core.sv -----
// ----------------------------------------------------------------------------
// Beam statistics core testbench
// Drives gate samples through the valid/ready request channel, predicts every
// beam summary from a local model of the gating, thresholds and file-wide
// figures, and compares each summary transaction field by field.
// Registers are reprogrammed over APB between phases, with extremes,
// and the response side is throttled and held off to exercise back-pressure.
// ----------------------------------------------------------------------------
module tb_gated_qc_beam_statistics_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gqbs_pkg::*;

   localparam int CycleLimit  = 600000;
   localparam int DrainCycles = 30;
   localparam int RandomItems = 580;

   typedef struct packed {
      logic [CountW-1:0]  n_accepted;
      logic [SampleW-1:0] lo;
      logic [SampleW-1:0] hi;
      logic [MeanW-1:0]   mean;
      logic [MeanW-1:0]   lowest;
      logic [MeanW-1:0]   highest;
      logic [TotalW-1:0]  total;
      logic               valid;
   } beam_summary_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SampleW-1:0]  req_sample = '0;
   logic                       req_beam_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic        [CountW-1:0]   rsp_beam_count;
   logic signed [SampleW-1:0]  rsp_beam_min;
   logic signed [SampleW-1:0]  rsp_beam_max;
   logic signed [MeanW-1:0]    rsp_beam_mean;
   logic signed [MeanW-1:0]    rsp_overall_min_mean;
   logic signed [MeanW-1:0]    rsp_overall_max_mean;
   logic        [TotalW-1:0]   rsp_overall_count;
   logic                       rsp_overall_valid;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic        [AddrW-1:0]    paddr = '0;
   logic        [DataW-1:0]    pwdata = '0;
   logic        [DataW-1:0]    prdata;
   logic                       pready;

   gated_qc_beam_statistics_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample           (req_sample),
      .req_beam_end         (req_beam_end),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_beam_count       (rsp_beam_count),
      .rsp_beam_min         (rsp_beam_min),
      .rsp_beam_max         (rsp_beam_max),
      .rsp_beam_mean        (rsp_beam_mean),
      .rsp_overall_min_mean (rsp_overall_min_mean),
      .rsp_overall_max_mean (rsp_overall_max_mean),
      .rsp_overall_count    (rsp_overall_count),
      .rsp_overall_valid    (rsp_overall_valid),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register mirror
   int cfg_first   = 0;
   int cfg_final   = 4095;
   int cfg_qc_low  = -32768;
   int cfg_qc_high = 32767;

   // beam and file-wide statistics
   int     gate_idx   = 0;
   longint beam_sum   = 0;
   int     beam_cnt   = 0;
   int     beam_lo    = 0;
   int     beam_hi    = 0;
   longint file_total = 0;
   int     file_lowest  = 0;
   int     file_highest = 0;
   bit     file_seen  = 1'b0;

   beam_summary_type expected_summaries[$];
   beam_summary_type want_summary;
   beam_summary_type got_summary;

   int errors        = 0;
   int samples_sent  = 0;
   int beams_checked = 0;
   int empty_beams   = 0;
   int csr_writes    = 0;
   int random_items  = 0;
   int burst_left    = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int mode_left     = 0;
   int cycle_count   = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   function automatic void update_beam_stats(input logic signed [SampleW-1:0] sample,
                                             input logic last, output bit emitted,
                                             output beam_summary_type summ);
      int     s;
      longint m;
      s = sample;
      m = 0;
      emitted = 1'b0;
      summ = '0;
      if (gate_idx < MaxGates && gate_idx >= cfg_first && gate_idx <= cfg_final &&
          s > cfg_qc_low && s < cfg_qc_high) begin
         if (beam_cnt == 0) begin
            beam_lo = s;
            beam_hi = s;
         end else begin
            if (s < beam_lo) beam_lo = s;
            if (s > beam_hi) beam_hi = s;
         end
         beam_sum += s;
         beam_cnt++;
      end
      if (gate_idx < MaxGates) gate_idx++;
      if (!last) return;
      if (beam_cnt > 0) begin
         m = (beam_sum * 256) / longint'(beam_cnt);
         if (!file_seen) begin
            file_seen    = 1'b1;
            file_lowest  = int'(m);
            file_highest = int'(m);
         end else begin
            if (m < file_lowest) file_lowest = int'(m);
            if (m > file_highest) file_highest = int'(m);
         end
         file_total += beam_cnt;
         if (file_total > 64'hFFFF_FFFF) file_total = 64'hFFFF_FFFF;
      end
      emitted         = 1'b1;
      summ.n_accepted = beam_cnt[CountW-1:0];
      summ.lo         = beam_lo[SampleW-1:0];
      summ.hi         = beam_hi[SampleW-1:0];
      summ.mean       = m[MeanW-1:0];
      summ.lowest     = file_lowest[MeanW-1:0];
      summ.highest    = file_highest[MeanW-1:0];
      summ.total      = file_total[TotalW-1:0];
      summ.valid      = file_seen;
      gate_idx = 0;
      beam_sum = 0;
      beam_cnt = 0;
      beam_lo  = 0;
      beam_hi  = 0;
   endfunction

   function automatic logic [SampleW-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 65535)) - 32768;
         6:                v = cfg_qc_low + int'($urandom_range(0, 2)) - 1;
         7:                v = cfg_qc_high + int'($urandom_range(0, 2)) - 1;
         default:          v = int'($urandom_range(0, 400)) - 200;
      endcase
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[SampleW-1:0];
   endfunction

   task automatic send_sample(input logic signed [SampleW-1:0] sample, input logic last);
      int               gap;
      bit               emitted;
      beam_summary_type summ;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_sample   <= sample;
      req_beam_end <= last;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      update_beam_stats(sample, last, emitted, summ);
      if (emitted) begin
         expected_summaries.push_back(summ);
         if (summ.n_accepted == '0) empty_beams++;
      end
   endtask

   // lowers valid, waits for every outstanding summary, then idles
   task automatic drain_results(input int tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DataW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      csr_writes++;
      case (idx)
         REG_FIRST_GATE: cfg_first   = int'(value[CfgGateW-1:0]);
         REG_FINAL_GATE: cfg_final   = int'(value[CfgGateW-1:0]);
         REG_QC_LOW:     cfg_qc_low  = int'($signed(value[SampleW-1:0]));
         REG_QC_HIGH:    cfg_qc_high = int'($signed(value[SampleW-1:0]));
         default: ;
      endcase
   endtask

   task automatic send_beam(input int len);
      for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
   endtask

   task automatic test_default_config();
      // empty beam before any valid one
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd32767, 1'b1);
      // first valid beam, negative mean truncated toward zero
      send_sample(-16'sd32767, 1'b0);
      send_sample(16'sd32766, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sh1234, 1'b1);
   endtask

   task automatic test_gate_window();
      drain_results(DrainCycles);
      csr_write(REG_FIRST_GATE, 2);
      csr_write(REG_FINAL_GATE, 4);
      for (int k = 0; k < 6; k++) send_sample(SampleW'(100 - 37 * k), k == 5);
      drain_results(DrainCycles);
      csr_write(REG_FIRST_GATE, 5);
      csr_write(REG_FINAL_GATE, 3);
      for (int k = 0; k < 3; k++) send_sample(SampleW'(k - 1000), k == 2);
      drain_results(DrainCycles);
      csr_write(REG_FIRST_GATE, 0);
      csr_write(REG_FINAL_GATE, 0);
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd9, 1'b1);
      drain_results(DrainCycles);
      csr_write(REG_FINAL_GATE, 4095);
   endtask

   task automatic test_qc_thresholds();
      drain_results(DrainCycles);
      csr_write(REG_QC_LOW, -10);
      csr_write(REG_QC_HIGH, 10);
      send_sample(-16'sd10, 1'b0);
      send_sample(-16'sd9, 1'b0);
      send_sample(16'sd9, 1'b0);
      send_sample(16'sd10, 1'b1);
      drain_results(DrainCycles);
      csr_write(REG_QC_LOW, 32767);
      csr_write(REG_QC_HIGH, 32767);
      send_sample(16'sd32766, 1'b1);
      drain_results(DrainCycles);
      csr_write(REG_QC_LOW, -32768);
      csr_write(REG_QC_HIGH, -32768);
      send_sample(-16'sd32767, 1'b1);
      drain_results(DrainCycles);
      csr_write(REG_QC_HIGH, 32767);
   endtask

   task automatic test_mid_beam_write();
      send_sample(16'sd500, 1'b0);
      send_sample(-16'sd700, 1'b0);
      drain_results(DrainCycles);
      csr_write(REG_QC_HIGH, 0);
      send_sample(16'sd600, 1'b0);
      send_sample(-16'sd300, 1'b1);
      drain_results(DrainCycles);
      csr_write(REG_QC_HIGH, 32767);
   endtask

   task automatic test_backpressure();
      drain_results(DrainCycles);
      hold_request = 300;
      repeat (16) send_beam(2);
      drain_results(DrainCycles);
   endtask

   task automatic apply_random_config();
      int first_v, final_v, low_v, high_v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: first_v = 0;
         5:             first_v = 4095;
         6:             first_v = $urandom_range(0, 4095);
         default:       first_v = $urandom_range(0, 10);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: final_v = 4095;
         4:          final_v = 0;
         5:          final_v = $urandom_range(0, 4095);
         default:    final_v = $urandom_range(5, 60);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: low_v = -32768;
         3:       low_v = 32767;
         4:       low_v = int'($urandom_range(0, 65535)) - 32768;
         default: low_v = -int'($urandom_range(0, 25000));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: high_v = 32767;
         3:       high_v = -32768;
         4:       high_v = int'($urandom_range(0, 65535)) - 32768;
         default: high_v = $urandom_range(0, 25000);
      endcase
      csr_write(REG_FIRST_GATE, first_v);
      csr_write(REG_FINAL_GATE, final_v);
      csr_write(REG_QC_LOW, low_v);
      csr_write(REG_QC_HIGH, high_v);
   endtask

   task automatic test_random_phases();
      int phase_len, done, len;
      while (random_items < RandomItems) begin
         drain_results(DrainCycles);
         apply_random_config();
         phase_len = $urandom_range(30, 90);
         done = 0;
         while (done < phase_len) begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 120)
                                              : $urandom_range(1, 24);
            send_beam(len);
            done += len;
            random_items += len;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_summary.n_accepted = rsp_beam_count;
         got_summary.lo         = rsp_beam_min;
         got_summary.hi         = rsp_beam_max;
         got_summary.mean       = rsp_beam_mean;
         got_summary.lowest     = rsp_overall_min_mean;
         got_summary.highest    = rsp_overall_max_mean;
         got_summary.total      = rsp_overall_count;
         got_summary.valid      = rsp_overall_valid;
         if (expected_summaries.size() == 0) begin
            errors++;
            $display("%0t: unexpected summary transaction, expected none, actual count %h mean %h",
                     $time, rsp_beam_count, rsp_beam_mean);
         end else begin
            want_summary = expected_summaries.pop_front();
            check_field("beam_count", want_summary.n_accepted, got_summary.n_accepted);
            check_field("beam_min", want_summary.lo, got_summary.lo);
            check_field("beam_max", want_summary.hi, got_summary.hi);
            check_field("beam_mean", want_summary.mean, got_summary.mean);
            check_field("overall_min_mean", want_summary.lowest, got_summary.lowest);
            check_field("overall_max_mean", want_summary.highest, got_summary.highest);
            check_field("overall_count", want_summary.total, got_summary.total);
            check_field("overall_valid", want_summary.valid, got_summary.valid);
            beams_checked++;
         end
      end
   end

   // response-side throttling, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         case (ready_mode)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_RANDOM:   rsp_ready <= $urandom_range(0, 1);
            READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            default:        rsp_ready <= ((mode_left % 8) < 5);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d summaries outstanding", $time,
                  expected_summaries.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_config();
      test_gate_window();
      test_qc_thresholds();
      test_mid_beam_write();
      test_backpressure();
      test_random_phases();
      drain_results(DrainCycles);
      $display("Sent %0d samples, checked %0d beam summaries (%0d empty), %0d register writes.",
               samples_sent, beams_checked, empty_beams, csr_writes);
      $display("Covered gate windows, thresholds, mid-beam writes, back-pressure.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- gated_qc_beam_statistics_core.f -----
+incdir+rtl/core
rtl/core/gqbs_pkg.sv
rtl/core/gqbs_csr.sv
rtl/core/gqbs_ctrl.sv
rtl/core/gqbs_datapath.sv
rtl/core/gated_qc_beam_statistics_core.sv
tb/tb_gated_qc_beam_statistics_core.sv
